// ===== sv/sids_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sids_pkg: shared types and codes for the sequence insert/delete store
// Command and status codes, controller states and the control/status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package sids_pkg;

   localparam int CMD_W   = 3;
   localparam int POS_W   = 11;
   localparam int CNT_W   = 11;
   localparam int LEN_W   = 11;
   localparam int WORD_W  = 32;
   localparam int STAT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_APPEND,
      OP_INSERT,
      OP_DELETE,
      OP_READ,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT,
      S_FLUSH,
      S_PUTVAL,
      S_RWAIT,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the command and decode it
      logic shift;    // issue one move read; its write follows in the next cycle
      logic rd;       // issue the read of a read command
      logic rd_cap;   // capture read data
      logic put;      // write the new word
      logic commit;   // update length and load the result register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   err;
      logic   no_moves;
      logic   last_move;
   } dp_stat_type;

endpackage : sids_pkg
`default_nettype wire

// ===== sv/sids_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sids_req_if / sids_rsp_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sids_req_if;
   logic                              valid;
   logic                              ready;
   logic [sids_pkg::CMD_W-1:0]        cmd;
   logic [sids_pkg::POS_W-1:0]        position;
   logic [sids_pkg::CNT_W-1:0]        count;
   logic signed [sids_pkg::WORD_W-1:0] value;

   modport source (output valid, cmd, position, count, value, input ready);
   modport sink   (input valid, cmd, position, count, value, output ready);
endinterface : sids_req_if

interface sids_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sids_pkg::STAT_W-1:0]        status;
   logic signed [sids_pkg::WORD_W-1:0] read_value;
   logic [sids_pkg::LEN_W-1:0]         length;

   modport source (output valid, status, read_value, length, input ready);
   modport sink   (input valid, status, read_value, length, output ready);
endinterface : sids_rsp_if
`default_nettype wire

// ===== sv/sids_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sids_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sids_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule : sids_ram
`default_nettype wire

// ===== sv/sids_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sids_ctrl: command sequencer
// Accepts one command, steps the datapath through its moves and writes,
// and hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
module sids_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output sids_pkg::ctl_cmd_type      ctl,
   input  wire sids_pkg::dp_stat_type stat
);

   sids_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sids_pkg::S_IDLE: begin
            if (req_valid) state_in = sids_pkg::S_EXEC;
         end
         sids_pkg::S_EXEC: begin
            if (stat.err) begin
               state_in = sids_pkg::S_FINISH;
            end else begin
               case (stat.op)
                  sids_pkg::OP_APPEND: state_in = sids_pkg::S_PUTVAL;
                  sids_pkg::OP_INSERT:
                     state_in = stat.no_moves ? sids_pkg::S_PUTVAL : sids_pkg::S_SHIFT;
                  sids_pkg::OP_DELETE:
                     state_in = stat.no_moves ? sids_pkg::S_FINISH : sids_pkg::S_SHIFT;
                  sids_pkg::OP_READ:   state_in = sids_pkg::S_RWAIT;
                  default:             state_in = sids_pkg::S_FINISH;
               endcase
            end
         end
         sids_pkg::S_SHIFT: begin
            if (stat.last_move) state_in = sids_pkg::S_FLUSH;
         end
         sids_pkg::S_FLUSH: begin
            state_in = (stat.op == sids_pkg::OP_INSERT) ? sids_pkg::S_PUTVAL
                                                        : sids_pkg::S_FINISH;
         end
         sids_pkg::S_PUTVAL: state_in = sids_pkg::S_FINISH;
         sids_pkg::S_RWAIT:  state_in = sids_pkg::S_FINISH;
         sids_pkg::S_FINISH: begin
            if (out_free) state_in = sids_pkg::S_IDLE;
         end
         default: state_in = sids_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         sids_pkg::S_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         sids_pkg::S_EXEC: begin
            ctl.rd = !stat.err && (stat.op == sids_pkg::OP_READ);
         end
         sids_pkg::S_SHIFT:  ctl.shift  = 1'b1;
         sids_pkg::S_PUTVAL: ctl.put    = 1'b1;
         sids_pkg::S_RWAIT:  ctl.rd_cap = 1'b1;
         sids_pkg::S_FINISH: ctl.commit = out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sids_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : sids_ctrl
`default_nettype wire

// ===== sv/sids_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sids_dpath: length tracking, range checks and word moves
// Decodes a command against the current length, walks the store one word
// per cycle through the RAM for insert and delete, and holds the result.
// ----------------------------------------------------------------------------
module sids_dpath #(
   parameter int DEPTH = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [sids_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic [sids_pkg::POS_W-1:0]         req_position,
   input  wire logic [sids_pkg::CNT_W-1:0]         req_count,
   input  wire logic signed [sids_pkg::WORD_W-1:0] req_value,
   output logic [sids_pkg::STAT_W-1:0]             rsp_status,
   output logic signed [sids_pkg::WORD_W-1:0]      rsp_read_value,
   output logic [sids_pkg::LEN_W-1:0]              rsp_length,
   input  wire sids_pkg::ctl_cmd_type              ctl,
   output sids_pkg::dp_stat_type                   stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = ((LW > sids_pkg::POS_W) ? LW : sids_pkg::POS_W) + 1;

   // length and decoded command
   logic [LW-1:0]                   len_ff;
   logic [LW-1:0]                   nlen_ff, nlen_in;
   sids_pkg::op_type                op_ff, op_in;
   logic [sids_pkg::STAT_W-1:0]     st_ff, st_in;
   logic [AW-1:0]                   wpos_ff, wpos_in;
   logic signed [sids_pkg::WORD_W-1:0] val_ff;
   logic signed [sids_pkg::WORD_W-1:0] rd_ff;

   // move engine
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic          dir_ff, dir_in;   // high: walk down (insert)
   logic [LW-1:0] rem_ff, rem_in;
   logic [AW-1:0] wdst_ff;
   logic          wr_pend_ff;

   // result register
   logic [sids_pkg::STAT_W-1:0]        rsp_status_ff;
   logic signed [sids_pkg::WORD_W-1:0] rsp_value_ff;
   logic [sids_pkg::LEN_W-1:0]         rsp_length_ff;

   // RAM ports
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [sids_pkg::WORD_W-1:0] ram_wdata;
   logic [AW-1:0]               ram_raddr;
   logic [sids_pkg::WORD_W-1:0] ram_rdata;

   logic [CW-1:0] len_c, pos_c, cnt_c, end_c;
   logic          full;

   assign len_c = CW'(len_ff);
   assign pos_c = CW'(req_position);
   assign cnt_c = CW'(req_count);
   assign end_c = pos_c + cnt_c;
   assign full  = (len_ff == LW'(DEPTH));

   always_comb begin
      op_in   = sids_pkg::OP_NONE;
      st_in   = sids_pkg::STAT_OK;
      nlen_in = len_ff;
      wpos_in = AW'(req_position);
      src_in  = AW'(len_ff - LW'(1));
      dst_in  = AW'(len_ff);
      dir_in  = 1'b1;
      rem_in  = '0;
      case (req_cmd)
         sids_pkg::CMD_CLEAR: begin
            op_in   = sids_pkg::OP_CLEAR;
            nlen_in = '0;
         end
         sids_pkg::CMD_APPEND: begin
            op_in   = sids_pkg::OP_APPEND;
            wpos_in = AW'(len_ff);
            if (full) begin
               st_in = sids_pkg::STAT_FULL;
            end else begin
               nlen_in = len_ff + LW'(1);
            end
         end
         sids_pkg::CMD_INSERT: begin
            op_in = sids_pkg::OP_INSERT;
            if (full) begin
               st_in = sids_pkg::STAT_FULL;
            end else if (pos_c > len_c) begin
               st_in = sids_pkg::STAT_RANGE;
            end else begin
               nlen_in = len_ff + LW'(1);
               rem_in  = LW'(len_c - pos_c);
            end
         end
         sids_pkg::CMD_DELETE: begin
            op_in  = sids_pkg::OP_DELETE;
            dir_in = 1'b0;
            src_in = AW'(end_c);
            dst_in = AW'(req_position);
            if (end_c > len_c) begin
               st_in = sids_pkg::STAT_RANGE;
            end else if (req_count != '0) begin
               nlen_in = LW'(len_c - cnt_c);
               rem_in  = LW'(len_c - end_c);
            end
         end
         sids_pkg::CMD_READ: begin
            op_in = sids_pkg::OP_READ;
            if (pos_c >= len_c) st_in = sids_pkg::STAT_RANGE;
         end
         default: begin
            op_in = sids_pkg::OP_NONE;
         end
      endcase
      // advance the walk while moving
      if (ctl.shift) begin
         src_in = dir_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
         dst_in = dir_ff ? (dst_ff - AW'(1)) : (dst_ff + AW'(1));
         rem_in = rem_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         op_ff   <= op_in;
         st_ff   <= st_in;
         nlen_ff <= nlen_in;
         wpos_ff <= wpos_in;
         val_ff  <= req_value;
         rd_ff   <= '0;
         dir_ff  <= dir_in;
      end
      if (ctl.load || ctl.shift) begin
         src_ff <= src_in;
         dst_ff <= dst_in;
         rem_ff <= rem_in;
      end
      if (ctl.shift) begin
         wdst_ff <= dst_ff;
      end
      if (ctl.rd_cap) begin
         rd_ff <= $signed(ram_rdata);
      end
      if (ctl.commit) begin
         rsp_status_ff <= st_ff;
         rsp_value_ff  <= rd_ff;
         rsp_length_ff <= sids_pkg::LEN_W'(nlen_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= ctl.shift;
         if (ctl.commit) len_ff <= nlen_ff;
      end
   end

   // a move write lands the cycle after its read
   assign ram_we    = wr_pend_ff || ctl.put;
   assign ram_waddr = wr_pend_ff ? wdst_ff : wpos_ff;
   assign ram_wdata = wr_pend_ff ? ram_rdata : $unsigned(val_ff);
   assign ram_raddr = ctl.rd ? wpos_ff : src_ff;

   sids_ram #(
      .WIDTH (sids_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign stat.op        = op_ff;
   assign stat.err       = (st_ff != sids_pkg::STAT_OK);
   assign stat.no_moves  = (rem_ff == '0);
   assign stat.last_move = (rem_ff == LW'(1));

   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_length     = rsp_length_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(DEPTH))
      else $error("sids_dpath: length above store depth");
   a_shift_rem: assert property (@(posedge clock) disable iff (reset)
      ctl.shift |-> rem_ff != '0)
      else $error("sids_dpath: move issued with none left");
   a_wport: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> !ctl.put)
      else $error("sids_dpath: write port collision");
   a_commit_len: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> len_ff == $past(nlen_ff))
      else $error("sids_dpath: length not updated on commit");
`endif

endmodule : sids_dpath
`default_nettype wire

// ===== sv/sequence_insert_delete_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_insert_delete_store: positional edit store for 32-bit words
// Holds an ordered sequence of up to DEPTH words and edits it by position.
// req_bus carries one command per beat (clear, append, insert, delete, read)
// with position, count and value; rsp_bus returns one result beat per
// command: status, read data and the length after the command.
// Commands run one at a time. After the command beat the command is decoded
// (EXEC); an insert or delete then moves its m words through SHIFT and FLUSH,
// with m = length - position for an insert and m = length - position - count
// for a delete; an append or insert writes the new word (PUTVAL), a read
// waits for its RAM data (RWAIT), and FINISH loads the result register.
// Clear, rejects, unused codes and a delete with nothing to move go straight
// to FINISH. The next command beat can move at the same edge as the result
// beat; the longest command, an insert at the head, moves every word.
// Reset zeroes the length at once; store contents are undefined until
// written, and only positions below the length are ever read. A result waits
// in an output register while rsp_bus stalls; one more command is accepted
// and run, and its result is held until the register is taken.
// ----------------------------------------------------------------------------
module sequence_insert_delete_store #(
   parameter int DEPTH = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sids_req_if.sink   req_bus,
   sids_rsp_if.source rsp_bus
);

   sids_pkg::ctl_cmd_type ctl;
   sids_pkg::dp_stat_type stat;

   sids_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl),
      .stat      (stat)
   );

   sids_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_bus.cmd),
      .req_position   (req_bus.position),
      .req_count      (req_bus.count),
      .req_value      (req_bus.value),
      .rsp_status     (rsp_bus.status),
      .rsp_read_value (rsp_bus.read_value),
      .rsp_length     (rsp_bus.length),
      .ctl            (ctl),
      .stat           (stat)
   );

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("sequence_insert_delete_store: second command taken while busy");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> !rsp_bus.valid || rsp_bus.ready)
      else $error("sequence_insert_delete_store: result overwritten");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.status)
         && $stable(rsp_bus.read_value) && $stable(rsp_bus.length))
      else $error("sequence_insert_delete_store: stalled result beat changed");
`endif

endmodule : sequence_insert_delete_store
`default_nettype wire

// ===== verif/tb_sequence_insert_delete_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequence_insert_delete_store: self-checking bench for the edit store
// Plays directed and random command streams into the store with random
// gaps on both channels. Each command beat taken by the store is applied to
// a local copy of the word sequence, and each result beat is checked field
// by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_sequence_insert_delete_store;

   localparam int DEPTH     = 1024;
   localparam int N_RANDOM  = 550;
   localparam int HOLD_LEN  = 400;

   typedef struct {
      logic [sids_pkg::CMD_W-1:0]         cmd;
      logic [sids_pkg::POS_W-1:0]         position;
      logic [sids_pkg::CNT_W-1:0]         count;
      logic signed [sids_pkg::WORD_W-1:0] value;
      bit                                 drain;   // pause marker: wait for all results
   } edit_cmd_type;

   typedef struct {
      logic [sids_pkg::STAT_W-1:0]        status;
      logic signed [sids_pkg::WORD_W-1:0] read_value;
      logic [sids_pkg::LEN_W-1:0]         length;
   } edit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sids_req_if req_if ();
   sids_rsp_if rsp_if ();

   sequence_insert_delete_store #(.DEPTH(DEPTH)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always #1 clock = ~clock;

   // local copy of the sequence
   logic signed [sids_pkg::WORD_W-1:0] seq_words [DEPTH];
   int                                 seq_len = 0;

   edit_cmd_type    cmd_queue[$];
   edit_result_type pending_results[$];

   int plan_len     = 0;     // length the queued commands will leave behind
   int req_beats    = 0;
   int rsp_beats    = 0;
   int error_count  = 0;
   int n_ok         = 0;
   int n_full       = 0;
   int n_range      = 0;
   int longest      = 0;

   int beats_seen   = 0;
   int send_gap     = 0;
   int send_calm    = 0;
   int rsp_seen     = 0;
   int recv_gap     = 0;
   int recv_calm    = 0;
   int rsp_hold_left = 0;
   int hold_idx     = 0;

   function automatic edit_result_type apply_edit(edit_cmd_type c);
      edit_result_type r;
      int unsigned     p;
      int unsigned     n;
      int              i;
      r.status     = sids_pkg::STAT_OK;
      r.read_value = '0;
      p = c.position;
      n = c.count;
      case (c.cmd)
         sids_pkg::CMD_CLEAR: seq_len = 0;
         sids_pkg::CMD_APPEND: begin
            if (seq_len >= DEPTH) begin
               r.status = sids_pkg::STAT_FULL;
            end else begin
               seq_words[seq_len] = c.value;
               seq_len++;
            end
         end
         sids_pkg::CMD_INSERT: begin
            if (seq_len >= DEPTH) begin
               r.status = sids_pkg::STAT_FULL;
            end else if (p > seq_len) begin
               r.status = sids_pkg::STAT_RANGE;
            end else begin
               for (i = seq_len; i > p; i--) seq_words[i] = seq_words[i-1];
               seq_words[p] = c.value;
               seq_len++;
            end
         end
         sids_pkg::CMD_DELETE: begin
            if (p + n > seq_len) begin
               r.status = sids_pkg::STAT_RANGE;
            end else if (n != 0) begin
               for (i = p; i + n < seq_len; i++) seq_words[i] = seq_words[i+n];
               seq_len -= n;
            end
         end
         sids_pkg::CMD_READ: begin
            if (p >= seq_len) r.status = sids_pkg::STAT_RANGE;
            else r.read_value = seq_words[p];
         end
         default: ;
      endcase
      r.length = sids_pkg::LEN_W'(seq_len);
      return r;
   endfunction

   // mostly short gaps, a few long ones, and now and then a calm stretch
   function automatic int draw_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic queue_cmd(int unsigned cmd, int unsigned pos, int unsigned cnt,
                            logic [sids_pkg::WORD_W-1:0] val);
      edit_cmd_type c;
      c.cmd      = sids_pkg::CMD_W'(cmd);
      c.position = sids_pkg::POS_W'(pos);
      c.count    = sids_pkg::CNT_W'(cnt);
      c.value    = val;
      c.drain    = 1'b0;
      cmd_queue  = {cmd_queue, c};
      pos = c.position;
      cnt = c.count;
      case (c.cmd)
         sids_pkg::CMD_CLEAR:  plan_len = 0;
         sids_pkg::CMD_APPEND: if (plan_len < DEPTH) plan_len++;
         sids_pkg::CMD_INSERT: if (plan_len < DEPTH && pos <= plan_len) plan_len++;
         sids_pkg::CMD_DELETE: if (pos + cnt <= plan_len) plan_len -= cnt;
         default: ;
      endcase
   endtask

   task automatic queue_drain();
      edit_cmd_type c;
      c.cmd      = sids_pkg::CMD_CLEAR;
      c.position = '0;
      c.count    = '0;
      c.value    = '0;
      c.drain    = 1'b1;
      cmd_queue  = {cmd_queue, c};
   endtask

   // command driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && req_beats == beats_seen)) begin
         if (req_beats != beats_seen) begin
            beats_seen = req_beats;
            send_gap   = draw_gap(send_calm);
         end
         // pause: release only when every result is back
         if (cmd_queue.size() > 0 && cmd_queue[0].drain && pending_results.size() == 0)
            cmd_queue.delete(0);
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (cmd_queue.size() > 0 && !cmd_queue[0].drain) begin
            req_if.valid    <= 1'b1;
            req_if.cmd      <= cmd_queue[0].cmd;
            req_if.position <= cmd_queue[0].position;
            req_if.count    <= cmd_queue[0].count;
            req_if.value    <= cmd_queue[0].value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_beats != rsp_seen) begin
            rsp_seen = rsp_beats;
            recv_gap = draw_gap(recv_calm);
         end else if (recv_gap == 0 && $urandom_range(0, 19) == 0) begin
            recv_gap = draw_gap(recv_calm);
         end
         if (rsp_hold_left > 0) begin
            rsp_if.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off, twice per run, so the store backs up its input
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (!reset && hold_idx < 2 && req_beats >= 150 + 250 * hold_idx) begin
         rsp_hold_left <= HOLD_LEN;
         hold_idx      <= hold_idx + 1;
      end
   end

   // monitor: predict on each command beat, check each result beat
   always @(posedge clock) begin
      edit_cmd_type    c;
      edit_result_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_beats++;
            if (pending_results.size() == 0) begin
               $error("result beat with nothing expected: status %0d length %0d",
                      rsp_if.status, rsp_if.length);
               error_count++;
            end else begin
               want = pending_results[0];
               pending_results.delete(0);
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                  error_count++;
               end
               if (rsp_if.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value,
                         rsp_if.read_value);
                  error_count++;
               end
               if (rsp_if.length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_if.length);
                  error_count++;
               end
               case (want.status)
                  sids_pkg::STAT_OK:   n_ok++;
                  sids_pkg::STAT_FULL: n_full++;
                  default:             n_range++;
               endcase
               if (int'(want.length) > longest) longest = want.length;
            end
         end
         if (req_if.valid && req_if.ready) begin
            c.cmd      = req_if.cmd;
            c.position = req_if.position;
            c.count    = req_if.count;
            c.value    = req_if.value;
            c.drain    = 1'b0;
            pending_results = {pending_results, apply_edit(c)};
            cmd_queue.delete(0);
            req_beats++;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("sequence_insert_delete_store: mismatch");
      $finish;
   end

   initial begin
      int k;
      int j;
      int p;
      int run;
      int room;
      int pick;
      req_if.valid    = 1'b0;
      req_if.cmd      = '0;
      req_if.position = '0;
      req_if.count    = '0;
      req_if.value    = '0;
      rsp_if.ready    = 1'b0;

      // directed: empty store, extremes, every command and the edge cases
      queue_cmd(sids_pkg::CMD_READ, 0, 0, 0);
      queue_cmd(sids_pkg::CMD_DELETE, 0, 0, 0);
      queue_cmd(sids_pkg::CMD_DELETE, 0, 1, 0);
      queue_cmd(sids_pkg::CMD_INSERT, 1, 0, 32'd5);
      queue_cmd(sids_pkg::CMD_INSERT, 0, 0, 32'h8000_0000);
      queue_cmd(sids_pkg::CMD_APPEND, 0, 0, 32'h7FFF_FFFF);
      queue_cmd(sids_pkg::CMD_APPEND, 2047, 2047, 32'hFFFF_FFFF);
      queue_cmd(sids_pkg::CMD_INSERT, 3, 0, 32'h0);    // at the length: acts as append
      queue_cmd(sids_pkg::CMD_INSERT, 1, 2047, 32'h5555_5555);
      for (k = 0; k < 5; k++) queue_cmd(sids_pkg::CMD_READ, k, 0, 0);
      queue_cmd(sids_pkg::CMD_READ, 5, 0, 0);
      queue_cmd(sids_pkg::CMD_READ, 2047, 2047, 32'hFFFF_FFFF);
      queue_cmd(sids_pkg::CMD_READ, 1024, 0, 0);
      queue_cmd(sids_pkg::CMD_INSERT, 1024, 0, 32'h1234_5678);
      queue_cmd(sids_pkg::CMD_DELETE, 1024, 0, 0);
      queue_cmd(sids_pkg::CMD_DELETE, 1, 2, 0);
      queue_cmd(sids_pkg::CMD_DELETE, 3, 0, 0);
      queue_cmd(sids_pkg::CMD_DELETE, 2047, 2047, 0);
      queue_cmd(sids_pkg::CMD_DELETE, 0, 4, 0);
      for (k = 5; k < 8; k++)
         queue_cmd(k, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom());
      queue_cmd(sids_pkg::CMD_READ, 2, 0, 0);
      queue_cmd(sids_pkg::CMD_CLEAR, 2047, 2047, 32'hAAAA_AAAA);
      queue_cmd(sids_pkg::CMD_READ, 0, 0, 0);
      queue_drain();

      // random: mostly well-formed edits on a short sequence, some noise
      for (k = 0; k < N_RANDOM; k++) begin
         if (k % 120 == 119) queue_drain();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            queue_cmd($urandom_range(0, 7), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom());
         end else if (pick < 18) begin
            // a run of words inserted at consecutive positions
            p   = $urandom_range(0, plan_len);
            run = $urandom_range(2, 6);
            for (j = 0; j < run; j++)
               queue_cmd(sids_pkg::CMD_INSERT, p + j, $urandom_range(0, 2047), $urandom());
            k += run - 1;
         end else if (pick < 33) begin
            queue_cmd(sids_pkg::CMD_INSERT, $urandom_range(0, plan_len),
                      $urandom_range(0, 2047), $urandom());
         end else if (pick < 45) begin
            queue_cmd(sids_pkg::CMD_APPEND, $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom());
         end else if (pick < 58 || plan_len > 96) begin
            p    = $urandom_range(0, plan_len);
            room = plan_len - p;
            if (plan_len > 96)
               queue_cmd(sids_pkg::CMD_DELETE, p, $urandom_range(room / 2, room),
                         $urandom());
            else
               queue_cmd(sids_pkg::CMD_DELETE, p, $urandom_range(0, room < 8 ? room : 8),
                         $urandom());
         end else if (pick < 88) begin
            queue_cmd(sids_pkg::CMD_READ, plan_len > 0 ? $urandom_range(0, plan_len - 1) : 0,
                      $urandom_range(0, 2047), $urandom());
         end else begin
            // just past the bounds
            case ($urandom_range(0, 3))
               0: queue_cmd(sids_pkg::CMD_INSERT, plan_len + $urandom_range(1, 4), 0,
                            $urandom());
               1: queue_cmd(sids_pkg::CMD_READ, plan_len + $urandom_range(0, 3), 0, 0);
               2: begin
                  p = $urandom_range(0, plan_len);
                  queue_cmd(sids_pkg::CMD_DELETE, p, plan_len - p + $urandom_range(1, 3), 0);
               end
               default: queue_cmd(sids_pkg::CMD_DELETE, plan_len + 1, 0, 0);
            endcase
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() > 0 || pending_results.size() > 0) @(negedge clock);
      repeat (40) @(posedge clock);
      @(negedge clock);

      $display("Covered %0d commands (directed edge cases, random edits) and %0d results:",
               req_beats, rsp_beats);
      $display("  %0d ok, %0d full, %0d out of range; longest sequence %0d words.",
               n_ok, n_full, n_range, longest);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("sequence_insert_delete_store: match");
      end else begin
         $display("sequence_insert_delete_store: mismatch");
      end
      $finish;
   end

endmodule : tb_sequence_insert_delete_store

// ===== sim.f =====
sv/sids_pkg.sv
sv/sids_if.sv
sv/sids_ram.sv
sv/sids_ctrl.sv
sv/sids_dpath.sv
sv/sequence_insert_delete_store.sv
verif/tb_sequence_insert_delete_store.sv
